FILE: design/pdve_pkg.sv
// Package for the phase driven value easer: payload structs, per-channel record,
// controller/datapath command and status types, and the curve constants.
// No dependencies.
package pdve_pkg;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned CH_BITS    = 4;
  localparam int unsigned DIV_STEPS  = 18;
  localparam int unsigned CNT_BITS   = $clog2(DIV_STEPS);

  // Curve coefficients, Q30 and Q45
  localparam logic signed [47:0] C1_X      = 48'sd2147462173;
  localparam logic signed [47:0] C2_X      = 48'sd1073740750;
  localparam logic signed [47:0] Q45_ONE_X = 48'sh2000_0000_0000;

  typedef enum logic [0:0] {
    CFG_CURVE   = 1'b0,
    CFG_BIPOLAR = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_BITS-1:0]    channel;
    logic [VALUE_BITS-1:0] phase_now;
    logic [VALUE_BITS-1:0] target_value;
    logic                  restart;
  } easer_in_t;

  typedef struct packed {
    logic [CH_BITS-1:0]    out_channel;
    logic [VALUE_BITS-1:0] eased_value;
    logic                  settled;
  } easer_out_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] prev;
    logic [VALUE_BITS-1:0] pac;
    logic [15:0]           peak;
    logic                  fin;
    logic [VALUE_BITS-1:0] start;
    logic [VALUE_BITS-1:0] cur;
  } chan_rec_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_K1,
    OP_D,
    OP_PROD,
    OP_E,
    OP_NUM,
    OP_DSTART,
    OP_DSTEP,
    OP_CEND,
    OP_SQ,
    OP_CUBE,
    OP_G,
    OP_MAG,
    OP_RES
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   bi;
    logic   wb;
  } dp_cmd_t;

  typedef struct packed {
    logic init;
    logic a_nz;
    logic b_nz;
    logic ovf;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: design/pdve_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdve_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pdve_ctrl.sv
// Controller of the easer: sequences load, curve stages, division and ease.
// Depends on pdve_pkg.
module pdve_ctrl import pdve_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_LOAD = 16'h0002,
    S_K1   = 16'h0004,
    S_D    = 16'h0008,
    S_PROD = 16'h0010,
    S_E    = 16'h0020,
    S_NUM  = 16'h0040,
    S_DST  = 16'h0080,
    S_DIV  = 16'h0100,
    S_CEND = 16'h0200,
    S_SQ   = 16'h0400,
    S_CUBE = 16'h0800,
    S_G    = 16'h1000,
    S_MAG  = 16'h2000,
    S_RES  = 16'h4000,
    S_WB   = 16'h8000
  } state_e;

  state_e              state_q, state_d;
  logic                bi_q, bi_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d   = state_q;
    bi_d      = bi_q;
    cnt_d     = cnt_q;
    cmd_o.op  = OP_NONE;
    cmd_o.bi  = bi_q;
    cmd_o.wb  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        if (sts_i.init) begin
          state_d = S_WB;
        end else if (sts_i.a_nz) begin
          bi_d    = 1'b0;
          state_d = S_K1;
        end else if (sts_i.b_nz) begin
          bi_d    = 1'b1;
          state_d = S_K1;
        end else begin
          state_d = S_SQ;
        end
      end
      S_K1: begin
        cmd_o.op = OP_K1;
        state_d  = S_D;
      end
      S_D: begin
        cmd_o.op = OP_D;
        state_d  = S_PROD;
      end
      S_PROD: begin
        cmd_o.op = OP_PROD;
        state_d  = S_E;
      end
      S_E: begin
        cmd_o.op = OP_E;
        state_d  = S_NUM;
      end
      S_NUM: begin
        cmd_o.op = OP_NUM;
        state_d  = S_DST;
      end
      S_DST: begin
        cmd_o.op = OP_DSTART;
        cnt_d    = '0;
        // quotient beyond 18 bits saturates anyway: skip the division
        state_d  = sts_i.ovf ? S_CEND : S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DSTEP;
        if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
          state_d = S_CEND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_CEND: begin
        cmd_o.op = OP_CEND;
        if (!bi_q && sts_i.b_nz) begin
          bi_d    = 1'b1;
          state_d = S_K1;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.op = OP_CUBE;
        state_d  = S_G;
      end
      S_G: begin
        cmd_o.op = OP_G;
        state_d  = S_MAG;
      end
      S_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = S_RES;
      end
      S_RES: begin
        cmd_o.op = OP_RES;
        state_d  = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        // hold until the output register can take the beat
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bi_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      bi_q    <= bi_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: design/pdve_dp.sv
// Datapath of the easer: channel store, configuration registers, curve
// arithmetic with a radix-2 divider, cubic ease and output register.
// Depends on pdve_pkg and pdve_ram.
module pdve_dp import pdve_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16,
  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  easer_in_t        in_data_i,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output easer_out_t       out_data_o
);

  localparam int unsigned RW = $bits(chan_rec_t);

  // channel field to store index, reduced modulo the channel count
  logic [IW-1:0] chmap [2**CH_BITS];
  for (genvar g = 0; g < 2**CH_BITS; g++) begin : g_chmap
    assign chmap[g] = IW'(g % NUM_CHANNELS);
  end

  logic signed [15:0]    cfg_a_q, cfg_b_q;
  logic [NUM_CHANNELS-1:0] chv_q;
  logic                  out_valid_q;
  easer_out_t            out_q;

  easer_in_t             item_q;
  logic [IW-1:0]         idx_q;
  logic [VALUE_BITS-1:0] pac_q, start_q, res_q;
  logic [15:0]           peak_q, t_q;
  logic                  fin_q, settled_q;
  logic [16:0]           mag_q;
  logic                  neg_q;
  logic signed [47:0]    k1_q, d_q;
  logic signed [65:0]    p_q;
  logic [47:0]           n_q;
  logic [48:0]           e_q, rem_q;
  logic [64:0]           num_q;
  logic [DIV_STEPS-1:0]  dsh_q, q_q;
  logic                  ovf_q;
  logic [31:0]           tsq_q;
  logic [47:0]           tcube_q;
  logic [33:0]           g_q;
  logic [49:0]           m_q;

  chan_rec_t             rec_rd, rec_wr;
  logic [RW-1:0]         ram_rdata;

  pdve_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wb),
    .waddr_i (idx_q),
    .wdata_i (rec_wr),
    .re_i    (cmd_i.op == OP_LATCH),
    .raddr_i (chmap[in_data_i.channel]),
    .rdata_o (ram_rdata)
  );

  assign rec_rd = chan_rec_t'(ram_rdata);
  assign rec_wr = '{prev:  item_q.target_value, pac: pac_q, peak: peak_q, fin: fin_q,
                    start: start_q, cur: res_q};

  // combinational helpers for the current step
  logic                  init;
  logic                  tchg;
  logic [VALUE_BITS-1:0] pac_new;
  logic signed [15:0]    amt_s;
  logic signed [47:0]    amt_x;
  logic signed [48:0]    nsum;
  logic signed [49:0]    ptr;
  logic signed [50:0]    esum;
  logic                  ovf;
  logic [49:0]           rsh;
  logic [16:0]           r17;
  logic [17:0]           y18;
  logic [16:0]           h17;
  logic [15:0]           t_end;
  logic [49:0]           g48;
  logic [VALUE_BITS-1:0] dif;
  logic [17:0]           mhi, sum18;
  logic [VALUE_BITS-1:0] eased;

  always_comb begin
    init    = item_q.restart || !chv_q[idx_q];
    tchg    = rec_rd.prev != item_q.target_value;
    pac_new = tchg ? item_q.phase_now : rec_rd.pac;
    amt_s   = cmd_i.bi ? cfg_b_q : cfg_a_q;
    amt_x   = 48'(amt_s);
    nsum    = 49'(k1_q) + 49'(d_q);
    // round toward minus infinity: the whole sum with d is positive
    ptr     = 50'(p_q >>> 16);
    esum    = 51'(d_q) + 51'(ptr);
    ovf     = 49'(num_q[64:18]) >= e_q;
    rsh     = {rem_q, dsh_q[DIV_STEPS-1]};
    r17     = (ovf_q || (q_q > 18'd65536)) ? 17'd65536 : q_q[16:0];
    y18     = neg_q ? (18'd65536 - 18'(r17)) : (18'd65536 + 18'(r17));
    h17     = y18[17:1];
    if (cmd_i.bi) begin
      t_end = h17[16] ? 16'hFFFF : h17[15:0];
    end else begin
      t_end = r17[16] ? 16'hFFFF : r17[15:0];
    end
    g48     = (50'(t_q) << 31) + (50'(tsq_q) << 16) + (50'(tsq_q) << 15) - 50'(tcube_q);
    dif     = (item_q.target_value >= start_q) ? (item_q.target_value - start_q)
                                               : (start_q - item_q.target_value);
    mhi     = m_q[49:32];
    sum18   = 18'(start_q) + mhi;
    if (item_q.target_value >= start_q) begin
      eased = (sum18 > 18'(16'hFFFF)) ? 16'hFFFF : sum18[15:0];
    end else begin
      eased = (mhi > 18'(start_q)) ? '0 : (start_q - mhi[15:0]);
    end
  end

  assign sts_o.init     = init;
  assign sts_o.a_nz     = (cfg_a_q != '0);
  assign sts_o.b_nz     = (cfg_b_q != '0);
  assign sts_o.ovf      = ovf;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_a_q     <= '0;
      cfg_b_q     <= '0;
      chv_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CURVE:   cfg_a_q <= cfg_data_i;
          CFG_BIPOLAR: cfg_b_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.wb) begin
        chv_q[idx_q] <= 1'b1;
      end
      if (cmd_i.wb && sts_o.out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb && sts_o.out_free) begin
      out_q <= '{out_channel: item_q.channel, eased_value: res_q, settled: settled_q};
    end
    case (cmd_i.op)
      OP_LATCH: begin
        item_q <= in_data_i;
        idx_q  <= chmap[in_data_i.channel];
      end
      OP_LOAD: begin
        if (init) begin
          pac_q     <= item_q.phase_now;
          peak_q    <= '0;
          fin_q     <= 1'b0;
          start_q   <= item_q.target_value;
          res_q     <= item_q.target_value;
          settled_q <= 1'b1;
        end else begin
          pac_q   <= pac_new;
          peak_q  <= tchg ? '0 : rec_rd.peak;
          fin_q   <= tchg ? 1'b0 : rec_rd.fin;
          start_q <= tchg ? rec_rd.cur : rec_rd.start;
          t_q     <= item_q.phase_now - pac_new;
        end
      end
      OP_K1: begin
        k1_q <= amt_x * C1_X;
        if (!cmd_i.bi) begin
          mag_q <= {1'b0, t_q};
          neg_q <= 1'b0;
        end else if (t_q[15]) begin
          mag_q <= {1'b0, t_q[14:0], 1'b0};
          neg_q <= 1'b0;
        end else begin
          mag_q <= 17'd65536 - {t_q, 1'b0};
          neg_q <= 1'b1;
        end
      end
      OP_D: begin
        d_q <= Q45_ONE_X - amt_x * C2_X;
      end
      OP_PROD: begin
        p_q <= 66'(k1_q) * $signed({49'd0, mag_q});
        n_q <= nsum[48] ? '0 : nsum[47:0];
      end
      OP_E: begin
        e_q <= (esum[50] || (esum == '0)) ? 49'd1 : esum[48:0];
      end
      OP_NUM: begin
        num_q <= 65'(n_q) * 65'(mag_q);
      end
      OP_DSTART: begin
        rem_q <= 49'(num_q[64:18]);
        dsh_q <= num_q[17:0];
        q_q   <= '0;
        ovf_q <= ovf;
      end
      OP_DSTEP: begin
        if (rsh >= {1'b0, e_q}) begin
          rem_q <= 49'(rsh - {1'b0, e_q});
          q_q   <= {q_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_q <= rsh[48:0];
          q_q   <= {q_q[DIV_STEPS-2:0], 1'b0};
        end
        dsh_q <= {dsh_q[DIV_STEPS-2:0], 1'b0};
      end
      OP_CEND: begin
        t_q <= t_end;
      end
      OP_SQ: begin
        tsq_q <= 32'(t_q) * 32'(t_q);
        // a fall below the peak ends the ease
        if (t_q < peak_q) begin
          fin_q <= 1'b1;
        end else begin
          peak_q <= t_q;
        end
      end
      OP_CUBE: begin
        tcube_q <= 48'(tsq_q) * 48'(t_q);
      end
      OP_G: begin
        g_q <= g48[49:16];
      end
      OP_MAG: begin
        m_q <= 50'(dif) * 50'(g_q);
      end
      OP_RES: begin
        res_q     <= fin_q ? item_q.target_value : eased;
        settled_q <= fin_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/phase_driven_value_easer_unit.sv
// Phase driven value easer: top level joining controller and datapath.
// Depends on pdve_pkg, pdve_ctrl, pdve_dp (and pdve_ram below it).
//
// Usage: one input beat (channel, phasor, target, restart) gives one output
// beat (channel echo, eased value, settled flag). Both channels use valid and
// stall; a beat moves when valid is high and stall is low.
// Items are processed one at a time. A restart or first item on a channel
// goes from load straight to the output register. Otherwise each non-zero
// curve amount adds a coefficient set-up and an 18 step radix-2 division,
// skipped when the quotient saturates, before the cubic ease; one divider
// serves both. The next item is taken as soon as the result sits in the
// output register, so a held output beat does not block the input until the
// next result is ready. A stalled output beat stays put and the block waits
// for it. Reset clears all channels to unseen and both curve amounts to
// zero; there is no clearing pass. Curve amounts are to be written by
// cfg_we_i only while idle; the user, not the block, enforces this.
module phase_driven_value_easer_unit import pdve_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  easer_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output easer_out_t  out_data_o,
  input  logic        cfg_we_i,
  input  cfg_reg_e    cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pdve_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdve_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/pdve_checker.sv
// Port-level checks for the easer top level, bound to every instance.
// Depends on pdve_pkg.
module pdve_checker import pdve_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input easer_out_t out_data_o
);

  // a held output beat keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while item in flight");

  // a result appears only from a busy block
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat without item in flight");

endmodule

bind phase_driven_value_easer_unit pdve_checker u_pdve_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: verif/testbench.sv
// Testbench for phase_driven_value_easer_unit: drives items and curve amounts,
// predicts each result with a local model of the easing arithmetic and checks it.
// Depends on pdve_pkg and the RTL of the unit.
module testbench;
  import pdve_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH = 16;
  localparam longint LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  easer_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  easer_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_idx_i = CFG_CURVE;
  logic [15:0] cfg_data_i = '0;

  phase_driven_value_easer_unit #(.NUM_CHANNELS(NCH)) dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  bit              seen_q[NCH];
  bit [15:0]       prev_tgt_q[NCH];
  bit [15:0]       pac_q[NCH];
  bit [15:0]       peak_q[NCH];
  bit              fin_q[NCH];
  bit [15:0]       start_q[NCH];
  bit [15:0]       cur_q[NCH];
  logic signed [15:0] amt_uni, amt_bi;

  easer_out_t eased_fifo[$];
  int  errors = 0;
  bit  long_hold = 0;
  bit  stall_rand = 1;
  longint cycles = 0;

  function automatic longint shape_curve(longint x, longint amt);
    longint k1, d, n, mag, e, r;
    k1 = amt * 64'sd2147462173;
    d = (64'sd1 <<< 45) - amt * 64'sd1073740750;
    n = k1 + d;
    mag = (x < 0) ? -x : x;
    e = (k1 * mag + d * 65536) / 65536;
    if (e <= 0) e = 1;
    if (n < 0) n = 0;
    r = longint'(64'(n) * 64'(mag) / 64'(e));
    if (r > 65536) r = 65536;
    return (x < 0) ? -r : r;
  endfunction

  function automatic bit [15:0] ease_value(bit [63:0] s, bit [63:0] e, bit [63:0] t);
    bit [63:0] g, r, m;
    g = ((t << 31) + ((3 * t * t) << 15) - t * t * t) >> 16;
    if (e >= s) r = s + (((e - s) * g) >> 32);
    else begin
      m = ((s - e) * g) >> 32;
      r = (m > s) ? 0 : s - m;
    end
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic easer_out_t predict_eased(easer_in_t it);
    easer_out_t o;
    int ch;
    longint t, y, w;
    ch = it.channel % NCH;
    o.out_channel = it.channel;
    if (it.restart || !seen_q[ch]) begin
      seen_q[ch] = 1; prev_tgt_q[ch] = it.target_value; start_q[ch] = it.target_value;
      cur_q[ch] = it.target_value; pac_q[ch] = it.phase_now; peak_q[ch] = 0;
      fin_q[ch] = 0;
      o.eased_value = it.target_value; o.settled = 1;
      return o;
    end
    if (prev_tgt_q[ch] != it.target_value) begin
      pac_q[ch] = it.phase_now; fin_q[ch] = 0; peak_q[ch] = 0; start_q[ch] = cur_q[ch];
    end
    t = 16'(it.phase_now - pac_q[ch]);
    if (amt_uni != 0) begin
      y = shape_curve(t, longint'(amt_uni));
      t = (y > 65535) ? 65535 : y;
    end
    if (amt_bi != 0) begin
      w = 2 * t - 65536;
      y = (shape_curve(w, longint'(amt_bi)) + 65536) >>> 1;
      t = (y > 65535) ? 65535 : y;
    end
    if (t < peak_q[ch]) fin_q[ch] = 1;
    else peak_q[ch] = t[15:0];
    o.eased_value = fin_q[ch] ? it.target_value :
                    ease_value(64'(start_q[ch]), 64'(it.target_value), 64'(t));
    prev_tgt_q[ch] = it.target_value;
    cur_q[ch] = o.eased_value;
    o.settled = fin_q[ch];
    return o;
  endfunction

  // result checker and run-time limit
  always @(posedge clk_i) begin
    easer_out_t exp_beat;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (eased_fifo.size() == 0) begin
        $error("unexpected beat: channel %0d", out_data_o.out_channel);
        errors++;
      end else begin
        exp_beat = eased_fifo.pop_front();
        if (out_data_o.out_channel !== exp_beat.out_channel) begin
          $error("out_channel: expected %0d, got %0d", exp_beat.out_channel,
                 out_data_o.out_channel);
          errors++;
        end
        if (out_data_o.eased_value !== exp_beat.eased_value) begin
          $error("eased_value: expected %0d, got %0d", exp_beat.eased_value,
                 out_data_o.eased_value);
          errors++;
        end
        if (out_data_o.settled !== exp_beat.settled) begin
          $error("settled: expected %0d, got %0d", exp_beat.settled, out_data_o.settled);
          errors++;
        end
      end
    end
  end

  // receiver hold-off: random, with a long counted stretch on request
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 0;
      end else if (stall_rand && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(easer_in_t it, bit gaps = 1);
    // leave valid low between beats
    if (gaps && $urandom_range(0, 2) == 0)
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3))
        @(posedge clk_i);
    else
      @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    eased_fifo.push_back(predict_eased(it));
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (eased_fifo.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_amounts(logic [15:0] a, logic [15:0] b);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_CURVE; cfg_data_i <= a;
    @(posedge clk_i);
    cfg_idx_i <= CFG_BIPOLAR; cfg_data_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    amt_uni = a; amt_bi = b;
  endtask

  function automatic easer_in_t mk(int ch, int ph, int tg, bit rs);
    easer_in_t it;
    it.channel = 4'(ch); it.phase_now = 16'(ph); it.target_value = 16'(tg); it.restart = rs;
    return it;
  endfunction

  task automatic test_directed();
    send_item(mk(0, 0, 0, 0));
    send_item(mk(15, 16'hFFFF, 16'hFFFF, 0));
    send_item(mk(0, 100, 16'hFFFF, 0));
    send_item(mk(0, 20000, 16'hFFFF, 0));
    send_item(mk(0, 60000, 16'hFFFF, 0));
    send_item(mk(0, 90, 16'hFFFF, 0));      // phase wraps but stays above peak
    send_item(mk(0, 5000, 16'hFFFF, 0));
    send_item(mk(15, 0, 0, 0));
    send_item(mk(15, 32768, 0, 0));
    send_item(mk(15, 1, 0, 1));            // restart
    send_item(mk(7, 123, 4000, 0));
    send_item(mk(7, 40000, 60000, 0));
    send_item(mk(7, 65535, 60000, 0));
  endtask

  // glides: a new target and a phase sweep that advances with wrap, mixed with occasional random items and restarts
  task automatic test_glides(int n);
    int ch, ph, tg, k, steps;
    k = 0;
    while (k < n) begin
      ch = $urandom_range(0, 15);
      tg = $urandom_range(0, 65535);
      ph = $urandom_range(0, 65535);
      steps = $urandom_range(2, 12);
      for (int s = 0; s < steps && k < n; s++, k++) begin
        if ($urandom_range(0, 15) == 0) send_item(mk($urandom, $urandom, $urandom, $urandom));
        else send_item(mk(ch, ph, tg, $urandom_range(0, 40) == 0));
        ph = (ph + $urandom_range(0, 12000)) & 16'hFFFF;
      end
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1;
    for (int k = 0; k < 12; k++) send_item(mk($urandom, $urandom, $urandom, 0), 0);
  endtask

  initial begin
    amt_uni = 0; amt_bi = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_amounts(16'sd16384, 16'sd0);
    test_directed();
    write_amounts(16'h7FFF, 16'h8000);
    test_directed();
    test_backpressure();
    write_amounts(16'h8000, 16'h7FFF);
    test_glides(200);
    write_amounts(16'h0000, 16'h0000);
    test_glides(300);
    for (int r = 0; r < 4; r++) begin
      write_amounts(16'($urandom), 16'($urandom));
      test_glides(190);
    end
    stall_rand = 0;
    write_amounts(16'hC000, 16'h4000);
    test_glides(60);
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: phase_driven_value_easer_unit.f
design/pdve_pkg.sv
design/pdve_ram.sv
design/pdve_ctrl.sv
design/pdve_dp.sv
design/phase_driven_value_easer_unit.sv
design/pdve_checker.sv
verif/testbench.sv
